### hw/rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define PTS_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// checked at every edge, reset included
`define PTS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

### hw/rtl/ptsch_pkg.sv
package ptsch_pkg;

  localparam logic [15:0] MIN_PERIOD     = 16'd10;
  localparam logic [15:0] MAX_PERIOD     = 16'd60000;
  localparam logic [15:0] DEFAULT_PERIOD = 16'd1000;

  localparam int FRAME_MAX = 18;
  localparam int NUM_MEAS  = 6;

  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_MEAS = 2'd2;
  localparam logic [1:0] OP_POLL = 2'd3;

  localparam logic [1:0] MSG_REQUEST = 2'd0;

  localparam logic [1:0] KIND_RESPONSE  = 2'd0;
  localparam logic [1:0] KIND_ERROR     = 2'd1;
  localparam logic [1:0] KIND_TELEMETRY = 2'd2;

  localparam logic [7:0] ERR_MALFORMED = 8'd0;
  localparam logic [7:0] ERR_UNKNOWN   = 8'd1;
  localparam logic [7:0] ERR_INVALID   = 8'd2;

  localparam logic [4:0] LEN_ERROR     = 5'd1;
  localparam logic [4:0] LEN_RESPONSE  = 5'd4;
  localparam logic [4:0] LEN_TELEMETRY = 5'd18;

  localparam logic [7:0] REQ_LENGTH = 8'd4;

  localparam logic [1:0] REG_SCHEMA_VERSION = 2'd0;
  localparam logic [1:0] REG_SET_COMMAND    = 2'd1;
  localparam logic [1:0] REG_TELEM_COMMAND  = 2'd2;

  localparam logic [7:0] RESET_SCHEMA_VERSION = 8'd1;
  localparam logic [7:0] RESET_SET_COMMAND    = 8'd16;
  localparam logic [7:0] RESET_TELEM_COMMAND  = 8'd128;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  msg_type;
    logic [7:0]  req_command;
    logic [31:0] req_sequence;
    logic [7:0]  req_length;
    logic [31:0] req_payload;
    logic [2:0]  meas_index;
    logic [15:0] meas_value;
    logic [7:0]  device_state;
  } item_t;

  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [7:0]  frame_command;
    logic [31:0] frame_sequence;
    logic [4:0]  frame_length;
    logic [4:0]  byte_index;
    logic [7:0]  payload_byte;
    logic        last;
  } frame_t;

  typedef struct packed {
    logic [1:0]                 kind;
    logic [7:0]                 command;
    logic [31:0]                seq;
    logic [4:0]                 length;
    logic [FRAME_MAX-1:0][7:0]  bytes;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### hw/rtl/ptsch_queue.sv
module ptsch_queue
  import ptsch_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  desc_t     push_desc,
  input  logic      pop,
  output desc_t     head,
  output q_status_t status
);

  desc_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_AW:0]    count;

  assign status.full  = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/ptsch_front.sv
module ptsch_front
  import ptsch_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  item_t     item,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  q_status_t qstat,
  output logic      push,
  output desc_t     push_desc
);

  logic [7:0]  schema_version;
  logic [7:0]  set_command;
  logic [7:0]  telem_command;

  logic [31:0] timestamp;
  logic [31:0] elapsed;
  logic        enabled;
  logic [15:0] period;
  logic [31:0] next_seq;
  logic [15:0] meas [NUM_MEAS];

  logic [7:0]  p_schema;
  logic [7:0]  p_en;
  logic [15:0] p_per;
  logic        bad_payload;
  logic        set_ok;
  logic [7:0]  err_code;
  logic        due;
  logic        produces;
  logic        accept;

  assign p_schema = item.req_payload[31:24];
  assign p_en     = item.req_payload[23:16];
  assign p_per    = item.req_payload[15:0];

  assign bad_payload = (item.req_length != REQ_LENGTH) || (p_schema != schema_version) ||
                       (p_en > 8'd1) || (p_per < MIN_PERIOD) || (p_per > MAX_PERIOD);

  always_comb begin
    set_ok   = 1'b0;
    err_code = ERR_INVALID;
    if (item.msg_type != MSG_REQUEST) begin
      err_code = ERR_MALFORMED;
    end else if (item.req_command != set_command) begin
      err_code = ERR_UNKNOWN;
    end else if (!bad_payload) begin
      set_ok = 1'b1;
    end
  end

  assign due        = enabled && (elapsed >= {16'd0, period});
  assign produces   = (item.op == OP_SET) || ((item.op == OP_POLL) && due);
  assign item_ready = !qstat.full || !produces;
  assign accept     = item_valid && item_ready;
  assign push       = accept && produces;

  // frame contents are captured now so later writes cannot disturb them
  always_comb begin
    push_desc = '0;
    if (item.op == OP_POLL) begin
      push_desc.kind     = KIND_TELEMETRY;
      push_desc.command  = telem_command;
      push_desc.seq      = next_seq;
      push_desc.length   = LEN_TELEMETRY;
      push_desc.bytes[0] = schema_version;
      push_desc.bytes[1] = item.device_state;
      push_desc.bytes[2] = timestamp[31:24];
      push_desc.bytes[3] = timestamp[23:16];
      push_desc.bytes[4] = timestamp[15:8];
      push_desc.bytes[5] = timestamp[7:0];
      for (int i = 0; i < NUM_MEAS; i++) begin
        push_desc.bytes[6 + 2 * i] = meas[i][15:8];
        push_desc.bytes[7 + 2 * i] = meas[i][7:0];
      end
    end else begin
      push_desc.command  = item.req_command;
      push_desc.seq      = item.req_sequence;
      if (set_ok) begin
        push_desc.kind     = KIND_RESPONSE;
        push_desc.length   = LEN_RESPONSE;
        push_desc.bytes[0] = schema_version;
        push_desc.bytes[1] = {7'd0, p_en[0]};
        push_desc.bytes[2] = p_per[15:8];
        push_desc.bytes[3] = p_per[7:0];
      end else begin
        push_desc.kind     = KIND_ERROR;
        push_desc.length   = LEN_ERROR;
        push_desc.bytes[0] = err_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      schema_version <= RESET_SCHEMA_VERSION;
      set_command    <= RESET_SET_COMMAND;
      telem_command  <= RESET_TELEM_COMMAND;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCHEMA_VERSION: schema_version <= cfg_data;
        REG_SET_COMMAND:    set_command    <= cfg_data;
        REG_TELEM_COMMAND:  telem_command  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timestamp <= '0;
      elapsed   <= '0;
      enabled   <= 1'b0;
      period    <= DEFAULT_PERIOD;
      next_seq  <= 32'd1;
      for (int i = 0; i < NUM_MEAS; i++) begin
        meas[i] <= '0;
      end
    end else if (accept) begin
      case (item.op)
        OP_TICK: begin
          timestamp <= timestamp + 32'd1;
          if (enabled && (elapsed != '1)) begin
            elapsed <= elapsed + 32'd1;
          end
        end
        OP_SET: begin
          if (set_ok) begin
            enabled <= p_en[0];
            period  <= p_per;
            elapsed <= '0;
          end
        end
        OP_MEAS: begin
          // slots six and seven do not exist
          for (int i = 0; i < NUM_MEAS; i++) begin
            if (item.meas_index == 3'(i)) begin
              meas[i] <= item.meas_value;
            end
          end
        end
        OP_POLL: begin
          if (due) begin
            elapsed  <= '0;
            next_seq <= (next_seq == '1) ? 32'd1 : next_seq + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/ptsch_back.sv
module ptsch_back
  import ptsch_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  desc_t     head,
  input  q_status_t qstat,
  output logic      pop,
  output logic      frame_valid,
  input  logic      frame_ready,
  output frame_t    frame
);

  logic [4:0] idx;
  logic       load;
  logic       take;
  logic       at_end;
  frame_t     frame_next;

  assign load   = !frame_valid || frame_ready;
  assign take   = load && !qstat.empty;
  assign at_end = (idx + 5'd1 == head.length);
  assign pop    = take && at_end;

  always_comb begin
    frame_next.frame_kind     = head.kind;
    frame_next.frame_command  = head.command;
    frame_next.frame_sequence = head.seq;
    frame_next.frame_length   = head.length;
    frame_next.byte_index     = idx;
    frame_next.payload_byte   = head.bytes[idx];
    frame_next.last           = at_end;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      frame <= frame_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
      idx         <= '0;
    end else begin
      if (load) begin
        frame_valid <= !qstat.empty;
      end
      if (pop) begin
        idx <= '0;
      end else if (take) begin
        idx <= idx + 5'd1;
      end
    end
  end

endmodule

### hw/rtl/periodic_telemetry_scheduler.sv
// telemetry scheduler: ticks, set requests, measurement writes and polls
// item channel (item_valid/item_ready/item) carries one operation per transaction;
// frame channel (frame_valid/frame_ready/frame) carries one payload byte per
// transaction, with kind, command, sequence, length, index and a last flag
// configuration: cfg_we writes cfg_data to register cfg_index; the user must
// write only while the block is idle, as the block does not enforce it
// a frame-producing item sits in a two-entry frame queue; the back end then
// registers its first byte from the queue head onto the frame port
// a frame then streams one byte per cycle while the receiver is ready; frames
// are 1, 4 or 18 bytes long, sent by the byte serialiser of the back end
// ticks, measurement writes and polls that are not due are taken every cycle
// and never wait on the output side
// a stalled receiver holds the current byte; frame-producing items are then
// held off once two frames are queued
// reset clears time, elapsed, enable and measurements, sets the sequence to 1,
// restores default period and register values and empties the queue
module periodic_telemetry_scheduler
  import ptsch_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  item_t      item,
  output logic       frame_valid,
  input  logic       frame_ready,
  output frame_t     frame,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  q_status_t qstat;
  logic      push;
  logic      pop;
  desc_t     push_desc;
  desc_t     head;

  ptsch_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .qstat      (qstat),
    .push       (push),
    .push_desc  (push_desc)
  );

  ptsch_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .status    (qstat)
  );

  ptsch_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .qstat       (qstat),
    .pop         (pop),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

endmodule

### hw/rtl/ptsch_checker.sv
`include "assert_macros.svh"

module ptsch_checker
  import ptsch_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   frame_valid,
  input logic   frame_ready,
  input frame_t frame
);

  logic       stalled;
  logic       index_in_range;
  logic       last_matches;
  logic       mid_frame;
  logic [4:0] prev_succ;
  logic       index_steps;

  assign stalled        = frame_valid && !frame_ready;
  assign index_in_range = (frame.byte_index < frame.frame_length);
  assign last_matches   = (frame.last == (frame.byte_index + 5'd1 == frame.frame_length));
  assign mid_frame      = frame_valid && frame_ready && !frame.last;
  assign index_steps    = (frame.byte_index == prev_succ);

  always_ff @(posedge clk) begin
    prev_succ <= frame.byte_index + 5'd1;
  end

  `PTS_ASSERT_ALWAYS(a_quiet_after_reset, clk, rst |=> !frame_valid)

  `PTS_ASSERT(a_stall_holds, clk, rst, stalled |=> frame_valid && $stable(frame))

  `PTS_ASSERT(a_last_flag, clk, rst, frame_valid |-> index_in_range && last_matches)

  `PTS_ASSERT(a_bytes_contiguous, clk, rst, mid_frame |=> frame_valid && index_steps)

endmodule

bind periodic_telemetry_scheduler ptsch_checker u_ptsch_checker (.*);

### sim/periodic_telemetry_scheduler_test.sv
module periodic_telemetry_scheduler_test;
  import ptsch_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_STALL = 300;

  typedef enum int {
    FLAW_MSG_TYPE,
    FLAW_COMMAND,
    FLAW_LENGTH,
    FLAW_SCHEMA,
    FLAW_ENABLE,
    FLAW_PERIOD_LOW,
    FLAW_PERIOD_HIGH
  } set_flaw_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_ready;
  item_t      item = '0;
  logic       frame_valid;
  logic       frame_ready = 1'b0;
  frame_t     frame;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_SCHEMA_VERSION;
  logic [7:0] cfg_data = '0;

  periodic_telemetry_scheduler uut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // scheduler state as predicted
  logic [7:0]  schema_cfg = RESET_SCHEMA_VERSION;
  logic [7:0]  set_cmd_cfg = RESET_SET_COMMAND;
  logic [7:0]  telem_cmd_cfg = RESET_TELEM_COMMAND;
  logic [31:0] clock_ms = '0;
  logic [31:0] since_sent = '0;
  logic        sending_on = 1'b0;
  logic [15:0] send_period = DEFAULT_PERIOD;
  logic [31:0] telem_seq = 32'd1;
  logic [15:0] meas_slot [NUM_MEAS] = '{default: '0};

  item_t  pending_items [$];
  frame_t frames_due [$];
  int     items_planned = 0;
  int     items_taken = 0;
  int     fail_count = 0;
  int     send_gap_max = 14;
  int     recv_gap_max = 14;
  int     send_wait = 0;
  int     recv_wait = 0;
  int     long_asks = 0;
  int     long_served = 0;
  logic   offer;

  task automatic note_mismatch(input string what);
    fail_count++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic queue_frame(input logic [1:0] kind, input logic [7:0] cmd,
                             input logic [31:0] seq, input logic [4:0] len,
                             input logic [FRAME_MAX-1:0][7:0] body);
    frame_t f;
    int k;
    for (k = 0; k < int'(len); k++) begin
      f.frame_kind = kind;
      f.frame_command = cmd;
      f.frame_sequence = seq;
      f.frame_length = len;
      f.byte_index = 5'(k);
      f.payload_byte = body[k];
      f.last = (k == int'(len) - 1);
      frames_due.push_back(f);
    end
  endtask

  task automatic apply_item(input item_t it);
    logic [FRAME_MAX-1:0][7:0] body;
    logic [7:0]  code;
    logic        bad;
    logic [15:0] per;
    int          i;
    body = '0;
    bad = 1'b1;
    code = ERR_INVALID;
    per = it.req_payload[15:0];
    case (it.op)
      OP_TICK: begin
        clock_ms = clock_ms + 32'd1;
        if (sending_on && since_sent != 32'hFFFF_FFFF) since_sent = since_sent + 32'd1;
      end
      OP_SET: begin
        if (it.msg_type != MSG_REQUEST) code = ERR_MALFORMED;
        else if (it.req_command != set_cmd_cfg) code = ERR_UNKNOWN;
        else if (it.req_length != REQ_LENGTH || it.req_payload[31:24] != schema_cfg ||
                 it.req_payload[23:16] > 8'd1 || per < MIN_PERIOD || per > MAX_PERIOD)
          code = ERR_INVALID;
        else bad = 1'b0;
        if (bad) begin
          body[0] = code;
          queue_frame(KIND_ERROR, it.req_command, it.req_sequence, LEN_ERROR, body);
        end else begin
          sending_on = it.req_payload[16];
          send_period = per;
          since_sent = '0;
          body[0] = schema_cfg;
          body[1] = {7'd0, sending_on};
          body[2] = per[15:8];
          body[3] = per[7:0];
          queue_frame(KIND_RESPONSE, it.req_command, it.req_sequence, LEN_RESPONSE, body);
        end
      end
      OP_MEAS: begin
        if (it.meas_index < NUM_MEAS) meas_slot[it.meas_index] = it.meas_value;
      end
      OP_POLL: begin
        if (sending_on && since_sent >= send_period) begin
          since_sent = '0;
          body[0] = schema_cfg;
          body[1] = it.device_state;
          body[2] = clock_ms[31:24];
          body[3] = clock_ms[23:16];
          body[4] = clock_ms[15:8];
          body[5] = clock_ms[7:0];
          for (i = 0; i < NUM_MEAS; i++) begin
            body[6 + 2 * i] = meas_slot[i][15:8];
            body[7 + 2 * i] = meas_slot[i][7:0];
          end
          queue_frame(KIND_TELEMETRY, telem_cmd_cfg, telem_seq, LEN_TELEMETRY, body);
          telem_seq = (telem_seq == 32'hFFFF_FFFF) ? 32'd1 : telem_seq + 32'd1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_byte(input frame_t got);
    frame_t want;
    if (frames_due.size() == 0) begin
      note_mismatch($sformatf("frame byte with nothing expected: %h", got));
    end else begin
      want = frames_due.pop_front();
      if (got.frame_kind !== want.frame_kind)
        note_mismatch($sformatf("kind %0d, expected %0d", got.frame_kind, want.frame_kind));
      if (got.frame_command !== want.frame_command)
        note_mismatch($sformatf("command %h, expected %h",
                                got.frame_command, want.frame_command));
      if (got.frame_sequence !== want.frame_sequence)
        note_mismatch($sformatf("sequence %h, expected %h",
                                got.frame_sequence, want.frame_sequence));
      if (got.frame_length !== want.frame_length)
        note_mismatch($sformatf("length %0d, expected %0d",
                                got.frame_length, want.frame_length));
      if (got.byte_index !== want.byte_index)
        note_mismatch($sformatf("index %0d, expected %0d", got.byte_index, want.byte_index));
      if (got.payload_byte !== want.payload_byte)
        note_mismatch($sformatf("byte %0d of seq %h: %h, expected %h", want.byte_index,
                                want.frame_sequence, got.payload_byte, want.payload_byte));
      if (got.last !== want.last)
        note_mismatch($sformatf("last %b, expected %b at index %0d",
                                got.last, want.last, want.byte_index));
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_wait = 0;
    end else begin
      offer = item_valid;
      if (item_valid && item_ready) begin
        apply_item(item);
        items_taken++;
        offer = 1'b0;
        send_wait = $urandom_range(0, send_gap_max);
      end
      if (!offer) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_items.size() != 0) begin
          item <= pending_items.pop_front();
          offer = 1'b1;
        end
      end
      item_valid <= offer;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      frame_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (frame_valid && frame_ready) begin
        check_byte(frame);
        recv_wait = $urandom_range(0, recv_gap_max);
      end
      if (long_asks != long_served) begin
        long_served = long_asks;
        recv_wait = LONG_STALL;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        frame_ready <= 1'b0;
      end else begin
        frame_ready <= 1'b1;
      end
    end
  end

  function automatic item_t rand_item(input logic [1:0] op);
    item_t it;
    it.op = op;
    it.msg_type = 2'($urandom);
    it.req_command = 8'($urandom);
    it.req_sequence = $urandom;
    it.req_length = 8'($urandom);
    it.req_payload = $urandom;
    it.meas_index = 3'($urandom);
    it.meas_value = 16'($urandom);
    it.device_state = 8'($urandom);
    return it;
  endfunction

  function automatic item_t good_set(input logic en, input logic [15:0] per);
    item_t it;
    it = rand_item(OP_SET);
    it.msg_type = MSG_REQUEST;
    it.req_command = set_cmd_cfg;
    it.req_length = REQ_LENGTH;
    it.req_payload = {schema_cfg, 7'd0, en, per};
    return it;
  endfunction

  function automatic item_t broken_set(input set_flaw_t flaw);
    item_t it;
    it = good_set(1'b1, MIN_PERIOD + 16'($urandom_range(0, 20)));
    case (flaw)
      FLAW_MSG_TYPE: it.msg_type = 2'($urandom_range(1, 3));
      FLAW_COMMAND: it.req_command = set_cmd_cfg ^ 8'($urandom_range(1, 255));
      FLAW_LENGTH: it.req_length = REQ_LENGTH ^ 8'($urandom_range(1, 255));
      FLAW_SCHEMA: it.req_payload[31:24] = schema_cfg ^ 8'($urandom_range(1, 255));
      FLAW_ENABLE: it.req_payload[23:16] = 8'($urandom_range(2, 255));
      FLAW_PERIOD_LOW: it.req_payload[15:0] = 16'($urandom_range(0, MIN_PERIOD - 1));
      default: it.req_payload[15:0] = 16'($urandom_range(MAX_PERIOD + 1, 16'hFFFF));
    endcase
    return it;
  endfunction

  task automatic plan(input item_t it);
    items_planned++;
    pending_items.push_back(it);
  endtask

  // a set request, good or broken, or a random item, then a tick-heavy run closed by a poll
  task automatic plan_session(input int n);
    int made, run, r;
    logic [15:0] per;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 9);
      per = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(MIN_PERIOD, MAX_PERIOD))
                                        : 16'($urandom_range(MIN_PERIOD, MIN_PERIOD + 6));
      if (r < 6) plan(good_set($urandom_range(0, 5) != 0, per));
      else if (r < 9) plan(broken_set(set_flaw_t'($urandom_range(0, FLAW_PERIOD_HIGH))));
      else plan(rand_item(2'($urandom)));
      run = $urandom_range(8, 20);
      repeat (run) begin
        r = $urandom_range(0, 19);
        if (r < 15) plan(rand_item(OP_TICK));
        else if (r < 18) plan(rand_item(OP_MEAS));
        else plan(rand_item(OP_POLL));
      end
      plan(rand_item(OP_POLL));
      made += run + 2;
    end
  endtask

  task automatic settle();
    do @(posedge clk);
    while (items_taken != items_planned || frames_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SCHEMA_VERSION: schema_cfg = val;
      REG_SET_COMMAND: set_cmd_cfg = val;
      default: telem_cmd_cfg = val;
    endcase
  endtask

  task automatic write_all(input logic [7:0] schema, input logic [7:0] set_cmd,
                           input logic [7:0] telem_cmd);
    write_reg(REG_SCHEMA_VERSION, schema);
    write_reg(REG_SET_COMMAND, set_cmd);
    write_reg(REG_TELEM_COMMAND, telem_cmd);
  endtask

  initial begin
    item_t d;
    int f;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed, register values from reset
    plan(rand_item(OP_POLL));
    for (f = 0; f <= FLAW_PERIOD_HIGH; f++) begin
      d = broken_set(set_flaw_t'(f));
      if (f == FLAW_PERIOD_LOW) d.req_payload[15:0] = MIN_PERIOD - 16'd1;
      if (f == FLAW_PERIOD_HIGH) d.req_payload[15:0] = MAX_PERIOD + 16'd1;
      plan(d);
    end
    d = good_set(1'b1, MIN_PERIOD);
    d.req_sequence = 32'hFFFF_FFFF;
    plan(d);
    d = rand_item(OP_MEAS);
    d.meas_index = 3'd0;
    d.meas_value = 16'h8000;
    plan(d);
    d.meas_index = 3'd5;
    d.meas_value = 16'hFFFF;
    plan(d);
    d.meas_index = 3'd6;
    d.meas_value = 16'h1234;
    plan(d);
    d.meas_index = 3'd7;
    plan(d);
    plan(rand_item(OP_POLL));
    repeat (MIN_PERIOD) plan(rand_item(OP_TICK));
    d = rand_item(OP_POLL);
    d.device_state = 8'hFF;
    plan(d);
    plan(good_set(1'b0, MAX_PERIOD));
    plan(rand_item(OP_TICK));
    plan(rand_item(OP_POLL));
    settle();

    write_all(8'h00, 8'h00, 8'h00);
    plan_session(20);
    settle();

    // no idling on either side
    send_gap_max = 0;
    recv_gap_max = 0;
    write_all(8'hFF, 8'hFF, 8'hFF);
    plan_session(20);
    settle();

    // receiver held off while frame requests keep coming
    write_all(8'($urandom), 8'($urandom), 8'($urandom));
    long_asks++;
    repeat (6) plan(good_set(1'b1, MIN_PERIOD));
    repeat (12) plan(rand_item(OP_TICK));
    plan(rand_item(OP_POLL));
    plan(good_set(1'b1, MIN_PERIOD));
    settle();

    send_gap_max = 14;
    recv_gap_max = 14;
    write_all(8'($urandom), 8'($urandom), 8'($urandom));
    plan_session(20);
    settle();

    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/ptsch_pkg.sv
hw/rtl/ptsch_queue.sv
hw/rtl/ptsch_front.sv
hw/rtl/ptsch_back.sv
hw/rtl/periodic_telemetry_scheduler.sv
hw/rtl/ptsch_checker.sv
sim/periodic_telemetry_scheduler_test.sv
